// File: rtl/core/geofence_safety_monitor_unit_assert.svh
// Assertion macros shared by the geofence safety monitor.
`ifndef GEOFENCE_SAFETY_MONITOR_UNIT_ASSERT_SVH
`define GEOFENCE_SAFETY_MONITOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GSM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define GSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/gsm_pkg.sv
// Shared types, constants and the arctangent table of the geofence monitor.
package gsm_pkg;

	localparam int CORDIC_STEPS_DEF = 24;
	localparam int LAT_W = 31;
	localparam int LON_W = 32;
	localparam int ALT_W = 21;
	localparam int BAT_W = 10;
	localparam int DIST_W = 25;
	localparam int RAD_W = 20;
	localparam int CEIL_W = 20;
	localparam int IDX_W = 3;
	localparam int CFG_W = 20;

	// Opcodes of an input word.
	localparam logic [1:0] OP_TELEM = 2'd0;
	localparam logic [1:0] OP_GOTO = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_GEO_EN = 3'd0;
	localparam logic [IDX_W-1:0] REG_ALT_EN = 3'd1;
	localparam logic [IDX_W-1:0] REG_BAT_EN = 3'd2;
	localparam logic [IDX_W-1:0] REG_RADIUS = 3'd3;
	localparam logic [IDX_W-1:0] REG_CEILING = 3'd4;
	localparam logic [IDX_W-1:0] REG_FLOOR = 3'd5;

	typedef struct packed {
		logic geo_en;
		logic alt_en;
		logic bat_en;
		logic [RAD_W-1:0] radius;
		logic [CEIL_W-1:0] ceiling;
		logic [BAT_W-1:0] floor_lvl;
	} gsm_cfg_t;

	// One classified word handed from the front to the back.
	typedef struct packed {
		logic [1:0] op;
		logic signed [31:0] lat2;
		logic signed [31:0] lon2;
		logic signed [31:0] base_lat;
		logic signed [31:0] base_lon;
		logic signed [ALT_W-1:0] alt;
		logic [BAT_W-1:0] bat;
		logic hv;
	} gsm_item_t;

	typedef struct packed {
		logic home_known;
		logic signed [ALT_W-1:0] clamped_altitude;
		logic goto_accepted;
		logic land_request;
		logic [DIST_W-1:0] home_distance;
		logic violation;
	} gsm_res_t;

	// atan(2^-i) as a binary angle, one turn = 2^32.
	function automatic logic [29:0] atan_q(input logic [4:0] i);
		logic [29:0] r;
		case (i)
			5'd0: r = 30'h20000000;
			5'd1: r = 30'h12E4051E;
			5'd2: r = 30'h09FB385B;
			5'd3: r = 30'h051111D4;
			5'd4: r = 30'h028B0D43;
			5'd5: r = 30'h0145D7E1;
			5'd6: r = 30'h00A2F61E;
			5'd7: r = 30'h00517C55;
			5'd8: r = 30'h0028BE53;
			5'd9: r = 30'h00145F2F;
			5'd10: r = 30'h000A2F98;
			5'd11: r = 30'h000517CC;
			5'd12: r = 30'h00028BE6;
			5'd13: r = 30'h000145F3;
			5'd14: r = 30'h0000A2FA;
			5'd15: r = 30'h0000517D;
			5'd16: r = 30'h000028BE;
			5'd17: r = 30'h0000145F;
			5'd18: r = 30'h00000A30;
			5'd19: r = 30'h00000518;
			5'd20: r = 30'h0000028C;
			5'd21: r = 30'h00000146;
			5'd22: r = 30'h000000A3;
			5'd23: r = 30'h00000051;
			5'd24: r = 30'h00000029;
			5'd25: r = 30'h00000014;
			5'd26: r = 30'h0000000A;
			5'd27: r = 30'h00000005;
			5'd28: r = 30'h00000003;
			5'd29: r = 30'h00000001;
			5'd30: r = 30'h00000001;
			default: r = 30'h00000000;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/core/geofence_safety_monitor_unit.sv
// Top level of the geofence safety monitor: configuration registers and the two engines.
//
// Input words arrive on s_tvalid/s_tready with the opcode in s_tuser (telemetry,
// goto check or clear home) and latitude, longitude, altitude and battery in s_tdata.
// Each accepted word gives exactly one result word on m_tvalid/m_tready, in order.
// Registers are written over cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high and indexes above five are ignored. Write them only while idle.
// The front end takes a word, updates home and queues it (two entries).
// A word that needs the home distance holds the back end until its result is registered:
// four sine/cosine CORDIC runs, four multiplies, 32 square-root steps, one vectoring
// run and a hand-off, on one CORDIC stage, one multiplier and a dual root unit. Other
// words pass from idle through the output state straight into the result register.
// The result register frees the back end so it continues with the next queued word
// while a result waits; when m_tready is held low the queue fills and s_tready drops.
// Reset clears home, the queue, the result register and restores register defaults.
module geofence_safety_monitor_unit import gsm_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [95:0] s_tdata, // latitude, longitude, altitude, battery_level, zero pad
	input logic [1:0] s_tuser, // opcode
	output logic m_tvalid,
	input logic m_tready,
	// violation, home_distance, land_request, goto_accepted, clamped_altitude,
	// home_known, zero pad
	output logic [55:0] m_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data
);

	gsm_cfg_t cfg_q;
	logic q_valid, q_pop;
	gsm_item_t q_item;
	gsm_res_t res;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.geo_en <= 1'b1;
			cfg_q.alt_en <= 1'b1;
			cfg_q.bat_en <= 1'b1;
			cfg_q.radius <= RAD_W'(100);
			cfg_q.ceiling <= CEIL_W'(5000);
			cfg_q.floor_lvl <= BAT_W'(200);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GEO_EN: cfg_q.geo_en <= cfg_data[0];
				REG_ALT_EN: cfg_q.alt_en <= cfg_data[0];
				REG_BAT_EN: cfg_q.bat_en <= cfg_data[0];
				REG_RADIUS: cfg_q.radius <= cfg_data[RAD_W-1:0];
				REG_CEILING: cfg_q.ceiling <= cfg_data[CEIL_W-1:0];
				REG_FLOOR: cfg_q.floor_lvl <= cfg_data[BAT_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	gsm_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.opcode(s_tuser),
		.latitude(s_tdata[30:0]),
		.longitude(s_tdata[62:31]),
		.altitude(s_tdata[83:63]),
		.battery_level(s_tdata[93:84]),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop)
	);

	gsm_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.res_valid(m_tvalid),
		.res(res),
		.res_ready(m_tready)
	);

	assign m_tdata = {6'd0, res.home_known, res.clamped_altitude, res.goto_accepted,
		res.land_request, res.home_distance, res.violation};

	`include "geofence_safety_monitor_unit_assert.svh"

	`GSM_ASSERT_NOW(a_viol_needs_home, m_tvalid && m_tdata[0], m_tdata[49], "violation without home")
	`GSM_ASSERT_NOW(a_dist_needs_home, m_tvalid && (m_tdata[25:1] != '0), m_tdata[49], "stray distance")
	`GSM_ASSERT_NOW(a_land_xor_goto, m_tvalid, !(m_tdata[26] && m_tdata[27]), "land and goto flags together")
	`GSM_ASSERT_NEXT(a_pop_frees_queue, q_pop && !s_tvalid, s_tready, "queue still full after pop")

endmodule

// File: rtl/core/gsm_front.sv
// Front end: accepts words, tracks the home position and queues work for the back end.
module gsm_front import gsm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] opcode,
	input logic signed [LAT_W-1:0] latitude,
	input logic signed [LON_W-1:0] longitude,
	input logic signed [ALT_W-1:0] altitude,
	input logic [BAT_W-1:0] battery_level,
	output logic q_valid,
	output gsm_item_t q_item,
	input logic q_pop
);

	gsm_item_t slot_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic signed [31:0] base_lat_q, base_lon_q;
	logic hv_q;
	logic push, capture, clear;
	logic signed [31:0] lat_ext;
	gsm_item_t item;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = slot_q[rd_ptr_q];

	// Home is captured or dropped here, in arrival order.
	always_comb begin
		lat_ext = {latitude[LAT_W-1], latitude};
		clear = (opcode == OP_CLEAR);
		capture = (opcode == OP_TELEM) && !hv_q && (latitude != '0) && (longitude != '0);
		item.op = opcode;
		item.lat2 = lat_ext;
		item.lon2 = longitude;
		item.alt = altitude;
		item.bat = battery_level;
		if (clear) begin
			item.base_lat = '0;
			item.base_lon = '0;
			item.hv = 1'b0;
		end else if (capture) begin
			item.base_lat = lat_ext;
			item.base_lon = longitude;
			item.hv = 1'b1;
		end else begin
			item.base_lat = base_lat_q;
			item.base_lon = base_lon_q;
			item.hv = hv_q;
		end
	end

	// Home state and queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_lat_q <= '0;
			base_lon_q <= '0;
			hv_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				base_lat_q <= item.base_lat;
				base_lon_q <= item.base_lon;
				hv_q <= item.hv;
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item;
		end
	end

endmodule

// File: rtl/core/gsm_back.sv
// Back end: CORDIC, multiplier and square-root sequencer computing the home distance.
module gsm_back import gsm_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	input gsm_cfg_t cfg,
	input logic q_valid,
	input gsm_item_t q_item,
	output logic q_pop,
	output logic res_valid,
	output gsm_res_t res,
	input logic res_ready
);

	localparam int SW = $clog2(CORDIC_STEPS);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ANG = 3'd1;
	localparam logic [2:0] ST_ROT = 3'd2;
	localparam logic [2:0] ST_MUL = 3'd3;
	localparam logic [2:0] ST_SQRT = 3'd4;
	localparam logic [2:0] ST_VEC = 3'd5;
	localparam logic [2:0] ST_DIST = 3'd6;
	localparam logic [2:0] ST_OUT = 3'd7;
	localparam logic signed [34:0] GAIN_Q30 = 35'sd652032874;
	localparam logic signed [34:0] QUARTER = 35'sd1073741824;
	localparam logic signed [34:0] HALF = 35'sd2147483648;
	localparam logic signed [29:0] UNITS_TO_TURN = 30'sd320255974;
	localparam logic [26:0] DIST_SCALE = 27'd80060347;
	localparam logic signed [67:0] ONE_Q60 = 68'sd1 <<< 60;

	logic [2:0] st_q;
	logic [SW-1:0] cnt_q;
	logic [1:0] k_q;
	gsm_item_t item_q;
	logic signed [34:0] cx_q, cy_q, cz_q;
	logic neg_q;
	logic signed [31:0] s1_q, s2_q, c1_q, c2_q;
	logic signed [33:0] t1_q, t2_q;
	logic signed [67:0] acc_q;
	logic [63:0] va_q, vb_q, ra_q, rb_q, sb_q;
	logic [DIST_W-1:0] dist_q;
	logic res_valid_q;
	gsm_res_t res_q;

	logic last;
	logic signed [32:0] u;
	logic signed [62:0] uprod;
	logic [31:0] ang;
	logic signed [34:0] z0;
	logic neg0;
	logic sigma;
	logic signed [34:0] xsh, ysh, at, nx, ny, nz;
	logic signed [31:0] sres, cres;
	logic signed [33:0] ma, mb;
	logic signed [67:0] mprod, asum, aclamp;
	logic [63:0] ta, tb;
	logic [30:0] zc;
	logic [57:0] dprod;
	logic [58:0] dround;
	logic [26:0] draw;
	logic out_free;
	gsm_res_t res_n;

	assign last = (cnt_q == SW'(CORDIC_STEPS - 1));
	assign q_pop = (st_q == ST_IDLE) && q_valid;
	assign res_valid = res_valid_q;
	assign res = res_q;
	assign out_free = !res_valid_q || res_ready;

	// Binary angle of the current CORDIC run and its fold into the right half plane.
	always_comb begin
		case (k_q)
			2'd0: u = {item_q.lat2[31], item_q.lat2} - {item_q.base_lat[31], item_q.base_lat};
			2'd1: u = {item_q.lon2[31], item_q.lon2} - {item_q.base_lon[31], item_q.base_lon};
			2'd2: u = {item_q.base_lat[31], item_q.base_lat};
			default: u = {item_q.lat2[31], item_q.lat2};
		endcase
		uprod = u * UNITS_TO_TURN;
		ang = (k_q[1] == 1'b0) ? uprod[60:29] : uprod[59:28];
		z0 = {{3{ang[31]}}, ang};
		neg0 = 1'b0;
		if (z0 > QUARTER) begin
			z0 = z0 - HALF;
			neg0 = 1'b1;
		end else if (z0 < -QUARTER) begin
			z0 = z0 + HALF;
			neg0 = 1'b1;
		end
	end

	// One CORDIC micro-rotation, shared by rotation and vectoring.
	always_comb begin
		sigma = (st_q == ST_VEC) ? !(cy_q > 35'sd0) : (cz_q >= 35'sd0);
		xsh = cx_q >>> cnt_q;
		ysh = cy_q >>> cnt_q;
		at = {5'd0, atan_q(5'(cnt_q))};
		if (sigma) begin
			nx = cx_q - ysh;
			ny = cy_q + xsh;
			nz = cz_q - at;
		end else begin
			nx = cx_q + ysh;
			ny = cy_q - xsh;
			nz = cz_q + at;
		end
		sres = neg_q ? 32'(-ny) : ny[31:0];
		cres = neg_q ? 32'(-nx) : nx[31:0];
	end

	// Shared multiplier for the haversine term.
	always_comb begin
		case (k_q)
			2'd0: begin
				ma = 34'(s1_q);
				mb = 34'(s1_q);
			end
			2'd1: begin
				ma = 34'(c1_q);
				mb = 34'(c2_q);
			end
			2'd2: begin
				ma = 34'(s2_q);
				mb = 34'(s2_q);
			end
			default: begin
				ma = t1_q;
				mb = t2_q;
			end
		endcase
		mprod = ma * mb;
		asum = acc_q + mprod;
		if (asum < 68'sd0) begin
			aclamp = '0;
		end else if (asum > ONE_Q60) begin
			aclamp = ONE_Q60;
		end else begin
			aclamp = asum;
		end
	end

	// Square-root trial subtractions for both roots.
	always_comb begin
		ta = ra_q + sb_q;
		tb = rb_q + sb_q;
	end

	// Central angle to meters.
	always_comb begin
		if (cz_q < 35'sd0) begin
			zc = '0;
		end else if (cz_q > QUARTER) begin
			zc = 31'(QUARTER);
		end else begin
			zc = cz_q[30:0];
		end
		dprod = zc * DIST_SCALE;
		dround = {1'b0, dprod} + (59'd1 << 31);
		draw = dround[58:32];
	end

	// Result fields of the finished word.
	always_comb begin
		res_n = '0;
		res_n.home_known = item_q.hv;
		case (item_q.op)
			OP_TELEM: begin
				res_n.home_distance = dist_q;
				res_n.violation = cfg.geo_en && item_q.hv &&
					((dist_q > DIST_W'(cfg.radius)) ||
					(cfg.alt_en && (item_q.alt > $signed({1'b0, cfg.ceiling}))));
				res_n.land_request = cfg.bat_en && (item_q.bat != '0) &&
					(item_q.bat < cfg.floor_lvl);
			end
			OP_GOTO: begin
				res_n.home_distance = dist_q;
				res_n.goto_accepted = !(cfg.geo_en && item_q.hv &&
					(dist_q > DIST_W'(cfg.radius)));
				if (cfg.alt_en && (item_q.alt > $signed({1'b0, cfg.ceiling}))) begin
					res_n.clamped_altitude = $signed({1'b0, cfg.ceiling});
				end else begin
					res_n.clamped_altitude = item_q.alt;
				end
			end
			default: begin
				res_n.home_distance = '0;
			end
		endcase
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			k_q <= 2'd0;
			res_valid_q <= 1'b0;
		end else begin
			// A new result replaces the old one in the cycle it is taken.
			if (st_q == ST_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					k_q <= 2'd0;
					if (q_valid) begin
						if (q_item.hv && (q_item.op == OP_TELEM || q_item.op == OP_GOTO)) begin
							st_q <= ST_ANG;
						end else begin
							st_q <= ST_OUT;
						end
					end
				end
				ST_ANG: begin
					cnt_q <= '0;
					st_q <= ST_ROT;
				end
				ST_ROT: begin
					cnt_q <= cnt_q + SW'(1);
					if (last) begin
						k_q <= k_q + 2'd1;
						st_q <= (k_q == 2'd3) ? ST_MUL : ST_ANG;
					end
				end
				ST_MUL: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						st_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					cnt_q <= '0;
					if (sb_q == 64'd1) begin
						st_q <= ST_VEC;
					end
				end
				ST_VEC: begin
					cnt_q <= cnt_q + SW'(1);
					if (last) begin
						st_q <= ST_DIST;
					end
				end
				ST_DIST: begin
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				item_q <= q_item;
				dist_q <= '0;
			end
			ST_ANG: begin
				cx_q <= GAIN_Q30;
				cy_q <= '0;
				cz_q <= z0;
				neg_q <= neg0;
			end
			ST_ROT: begin
				cx_q <= nx;
				cy_q <= ny;
				cz_q <= nz;
				if (last) begin
					case (k_q)
						2'd0: s1_q <= sres;
						2'd1: s2_q <= sres;
						2'd2: c1_q <= cres;
						default: c2_q <= cres;
					endcase
				end
			end
			ST_MUL: begin
				case (k_q)
					2'd0: acc_q <= mprod;
					2'd1: t1_q <= 34'(mprod >>> 30);
					2'd2: t2_q <= 34'(mprod >>> 30);
					default: begin
						va_q <= aclamp[63:0];
						vb_q <= 64'(ONE_Q60 - aclamp);
						ra_q <= '0;
						rb_q <= '0;
						sb_q <= 64'd1 << 62;
					end
				endcase
			end
			ST_SQRT: begin
				if (va_q >= ta) begin
					va_q <= va_q - ta;
					ra_q <= (ra_q >> 1) + sb_q;
				end else begin
					ra_q <= ra_q >> 1;
				end
				if (vb_q >= tb) begin
					vb_q <= vb_q - tb;
					rb_q <= (rb_q >> 1) + sb_q;
				end else begin
					rb_q <= rb_q >> 1;
				end
				sb_q <= sb_q >> 2;
				// The vectoring run starts from the two roots once both are done.
				if (sb_q == 64'd1) begin
					cx_q <= (vb_q >= tb) ? 35'((rb_q >> 1) + sb_q) : 35'(rb_q >> 1);
					cy_q <= (va_q >= ta) ? 35'((ra_q >> 1) + sb_q) : 35'(ra_q >> 1);
					cz_q <= '0;
				end
			end
			ST_VEC: begin
				cx_q <= nx;
				cy_q <= ny;
				cz_q <= nz;
			end
			ST_DIST: begin
				dist_q <= (draw > 27'(2 ** DIST_W - 1)) ? '1 : draw[DIST_W-1:0];
			end
			ST_OUT: begin
				if (out_free) begin
					res_q <= res_n;
				end
			end
			default: begin
				dist_q <= dist_q;
			end
		endcase
	end

endmodule
